@@ hw/rtl/tlpd_pkg.sv @@
// Shared constants and types for the two-level long press detector.
package tlpd_pkg;

   localparam int TIME_BITS_DEFAULT = 20;
   localparam int CSR_ADDR_BITS = 5;
   localparam int CSR_DATA_BITS = 32;
   localparam int REQ_DATA_BITS = 8;
   localparam int RSP_DATA_BITS = 8;

   localparam logic [31:0] AP_HOLD_RESET = 32'd5000;
   localparam logic [31:0] FACTORY_HOLD_RESET = 32'd10000;
   localparam logic [31:0] AP_OPEN_RESET = 32'd60000;

   localparam logic [2:0] REG_BUTTON_ENABLED = 3'd0;
   localparam logic [2:0] REG_ACTIVE_HIGH = 3'd1;
   localparam logic [2:0] REG_AP_HOLD = 3'd2;
   localparam logic [2:0] REG_FACTORY_HOLD = 3'd3;
   localparam logic [2:0] REG_AP_OPEN = 3'd4;

   localparam logic [1:0] EVT_NONE = 2'd0;
   localparam logic [1:0] EVT_AP = 2'd1;
   localparam logic [1:0] EVT_FACTORY = 2'd2;

   typedef struct packed {
      logic       stop_ap;
      logic       start_ap;
      logic [1:0] reset_event;
   } result_type;

endpackage

@@ hw/rtl/tlpd_csr.sv @@
// Configuration register file with an APB-style access port.
module tlpd_csr #(
   parameter int TIME_BITS = tlpd_pkg::TIME_BITS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [tlpd_pkg::CSR_ADDR_BITS-1:0]  csr_paddr,
   input  logic [tlpd_pkg::CSR_DATA_BITS-1:0]  csr_pwdata,
   output logic [tlpd_pkg::CSR_DATA_BITS-1:0]  csr_prdata,
   output logic                                csr_pready,
   output logic                                button_enabled,
   output logic                                active_high,
   output logic [TIME_BITS-1:0]                ap_hold_ms,
   output logic [TIME_BITS-1:0]                factory_hold_ms,
   output logic [TIME_BITS-1:0]                ap_open_ms
);

   logic                 enabled_ff, enabled_in;
   logic                 active_high_ff, active_high_in;
   logic [TIME_BITS-1:0] ap_hold_ff, ap_hold_in;
   logic [TIME_BITS-1:0] factory_hold_ff, factory_hold_in;
   logic [TIME_BITS-1:0] ap_open_ff, ap_open_in;
   logic                 write_en;
   logic [2:0]           reg_index;

   assign csr_pready = 1'b1;
   assign write_en = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign reg_index = csr_paddr[4:2];

   always_comb begin
      enabled_in = enabled_ff;
      active_high_in = active_high_ff;
      ap_hold_in = ap_hold_ff;
      factory_hold_in = factory_hold_ff;
      ap_open_in = ap_open_ff;
      if (write_en) begin
         unique case (reg_index)
            tlpd_pkg::REG_BUTTON_ENABLED: enabled_in = csr_pwdata[0];
            tlpd_pkg::REG_ACTIVE_HIGH:    active_high_in = csr_pwdata[0];
            tlpd_pkg::REG_AP_HOLD:        ap_hold_in = csr_pwdata[TIME_BITS-1:0];
            tlpd_pkg::REG_FACTORY_HOLD:   factory_hold_in = csr_pwdata[TIME_BITS-1:0];
            tlpd_pkg::REG_AP_OPEN:        ap_open_in = csr_pwdata[TIME_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enabled_ff <= 1'b0;
         active_high_ff <= 1'b0;
         ap_hold_ff <= tlpd_pkg::AP_HOLD_RESET[TIME_BITS-1:0];
         factory_hold_ff <= tlpd_pkg::FACTORY_HOLD_RESET[TIME_BITS-1:0];
         ap_open_ff <= tlpd_pkg::AP_OPEN_RESET[TIME_BITS-1:0];
      end else begin
         enabled_ff <= enabled_in;
         active_high_ff <= active_high_in;
         ap_hold_ff <= ap_hold_in;
         factory_hold_ff <= factory_hold_in;
         ap_open_ff <= ap_open_in;
      end
   end

   always_comb begin
      csr_prdata = '0;
      unique case (reg_index)
         tlpd_pkg::REG_BUTTON_ENABLED: csr_prdata[0] = enabled_ff;
         tlpd_pkg::REG_ACTIVE_HIGH:    csr_prdata[0] = active_high_ff;
         tlpd_pkg::REG_AP_HOLD:        csr_prdata[TIME_BITS-1:0] = ap_hold_ff;
         tlpd_pkg::REG_FACTORY_HOLD:   csr_prdata[TIME_BITS-1:0] = factory_hold_ff;
         tlpd_pkg::REG_AP_OPEN:        csr_prdata[TIME_BITS-1:0] = ap_open_ff;
         default: ;
      endcase
   end

   assign button_enabled = enabled_ff;
   assign active_high = active_high_ff;
   assign ap_hold_ms = ap_hold_ff;
   assign factory_hold_ms = factory_hold_ff;
   assign ap_open_ms = ap_open_ff;

endmodule

@@ hw/rtl/tlpd_core.sv @@
// Press tracking, hold thresholds and access point close countdown.
module tlpd_core #(
   parameter int TIME_BITS = tlpd_pkg::TIME_BITS_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 tick_accept,
   input  logic                 pin_level,
   input  logic                 ap_running,
   input  logic                 button_enabled,
   input  logic                 active_high,
   input  logic [TIME_BITS-1:0] ap_hold_ms,
   input  logic [TIME_BITS-1:0] factory_hold_ms,
   input  logic [TIME_BITS-1:0] ap_open_ms,
   output tlpd_pkg::result_type result
);

   logic                 pressed_ff, pressed_in;
   logic [TIME_BITS-1:0] hold_ff, hold_in;
   logic                 ap_fired_ff, ap_fired_in;
   logic                 factory_fired_ff, factory_fired_in;
   logic                 armed_ff, armed_in;
   logic [TIME_BITS-1:0] remain_ff, remain_in;
   logic [TIME_BITS-1:0] hold_next;
   logic                 active;

   assign hold_next = (hold_ff == '1) ? hold_ff : hold_ff + TIME_BITS'(1);
   assign active = active_high ? pin_level : ~pin_level;

   always_comb begin
      pressed_in = pressed_ff;
      hold_in = hold_ff;
      ap_fired_in = ap_fired_ff;
      factory_fired_in = factory_fired_ff;
      armed_in = armed_ff;
      remain_in = remain_ff;
      result = '{stop_ap: 1'b0, start_ap: 1'b0, reset_event: tlpd_pkg::EVT_NONE};
      if (tick_accept && button_enabled) begin
         if (armed_ff) begin
            if (remain_ff <= TIME_BITS'(1)) begin
               result.stop_ap = ap_running;
               armed_in = 1'b0;
               remain_in = '0;
            end else begin
               remain_in = remain_ff - TIME_BITS'(1);
            end
         end
         if (active) begin
            if (!pressed_ff) begin
               pressed_in = 1'b1;
               hold_in = '0;
               ap_fired_in = 1'b0;
               factory_fired_in = 1'b0;
            end else begin
               hold_in = hold_next;
               priority if (hold_next >= factory_hold_ms && !factory_fired_ff) begin
                  factory_fired_in = 1'b1;
                  result.reset_event = tlpd_pkg::EVT_FACTORY;
               end else if (hold_next >= ap_hold_ms && !ap_fired_ff && !factory_fired_ff) begin
                  if (!ap_running) begin
                     result.start_ap = 1'b1;
                     armed_in = 1'b1;
                     remain_in = ap_open_ms;
                  end
                  ap_fired_in = 1'b1;
                  result.reset_event = tlpd_pkg::EVT_AP;
               end else begin
               end
            end
         end else begin
            pressed_in = 1'b0;
            hold_in = '0;
            ap_fired_in = 1'b0;
            factory_fired_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pressed_ff <= 1'b0;
         hold_ff <= '0;
         ap_fired_ff <= 1'b0;
         factory_fired_ff <= 1'b0;
         armed_ff <= 1'b0;
         remain_ff <= '0;
      end else begin
         pressed_ff <= pressed_in;
         hold_ff <= hold_in;
         ap_fired_ff <= ap_fired_in;
         factory_fired_ff <= factory_fired_in;
         armed_ff <= armed_in;
         remain_ff <= remain_in;
      end
   end

endmodule

@@ hw/rtl/tlpd_out_buf.sv @@
// Result register with a skid stage so the input side can take one more result under a stall.
module tlpd_out_buf (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  tlpd_pkg::result_type push_data,
   output logic                 space,
   output logic                 out_valid,
   input  logic                 out_ready,
   output tlpd_pkg::result_type out_data
);

   logic                 main_valid_ff, main_valid_in;
   logic                 skid_valid_ff, skid_valid_in;
   tlpd_pkg::result_type main_data_ff, main_data_in;
   tlpd_pkg::result_type skid_data_ff, skid_data_in;
   logic                 pop;

   assign pop = main_valid_ff & out_ready;
   assign space = ~skid_valid_ff;

   always_comb begin
      main_valid_in = main_valid_ff;
      main_data_in = main_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in = skid_data_ff;
      if (pop || !main_valid_ff) begin
         if (skid_valid_ff) begin
            main_valid_in = 1'b1;
            main_data_in = skid_data_ff;
            skid_valid_in = 1'b0;
         end else begin
            main_valid_in = push;
            main_data_in = push_data;
         end
      end else if (push) begin
         skid_valid_in = 1'b1;
         skid_data_in = push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      main_data_ff <= main_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign out_valid = main_valid_ff;
   assign out_data = main_data_ff;

endmodule

@@ hw/rtl/two_level_long_press_detector_unit.sv @@
// Top level of the two-level long press detector for a reset button.
//
// Each transaction on the req_ channel is one 1 ms tick carrying the raw pin
// level and whether the access point is running. Each tick produces exactly one
// transaction on the rsp_ channel with the event code and the access point
// start and stop requests.
// The result is registered in the output buffer's main register, or in its skid
// stage when the receiver stalls; a new tick can be accepted in every cycle while
// req_tready is high, that is while the skid stage is empty.
// Configuration registers sit on the csr_ port at byte addresses 0, 4, 8, 12
// and 16; write them only while no tick is in flight.
// Reset clears the press state, the countdown and both result stages, disables
// the button and loads the default thresholds.
// When the receiver stalls, one more result is held in a skid stage, after
// which req_tready drops until the receiver takes a result.
module two_level_long_press_detector_unit #(
   parameter int TIME_BITS = tlpd_pkg::TIME_BITS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // Bit 0 pin_level, bit 1 ap_running, upper bits zero.
   input  logic [tlpd_pkg::REQ_DATA_BITS-1:0]  req_tdata,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // Bits 1:0 reset_event, bit 2 start_ap, bit 3 stop_ap, upper bits zero.
   output logic [tlpd_pkg::RSP_DATA_BITS-1:0]  rsp_tdata,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [tlpd_pkg::CSR_ADDR_BITS-1:0]  csr_paddr,
   input  logic [tlpd_pkg::CSR_DATA_BITS-1:0]  csr_pwdata,
   output logic [tlpd_pkg::CSR_DATA_BITS-1:0]  csr_prdata,
   output logic                                csr_pready
);

   logic                 button_enabled;
   logic                 active_high;
   logic [TIME_BITS-1:0] ap_hold_ms;
   logic [TIME_BITS-1:0] factory_hold_ms;
   logic [TIME_BITS-1:0] ap_open_ms;
   logic                 req_accept;
   logic                 buf_space;
   tlpd_pkg::result_type core_result;
   tlpd_pkg::result_type rsp_result;

   assign req_tready = buf_space;
   assign req_accept = req_tvalid & req_tready;

   tlpd_csr #(.TIME_BITS(TIME_BITS)) u_csr (
      .clock           (clock),
      .reset           (reset),
      .csr_psel        (csr_psel),
      .csr_penable     (csr_penable),
      .csr_pwrite      (csr_pwrite),
      .csr_paddr       (csr_paddr),
      .csr_pwdata      (csr_pwdata),
      .csr_prdata      (csr_prdata),
      .csr_pready      (csr_pready),
      .button_enabled  (button_enabled),
      .active_high     (active_high),
      .ap_hold_ms      (ap_hold_ms),
      .factory_hold_ms (factory_hold_ms),
      .ap_open_ms      (ap_open_ms)
   );

   tlpd_core #(.TIME_BITS(TIME_BITS)) u_core (
      .clock           (clock),
      .reset           (reset),
      .tick_accept     (req_accept),
      .pin_level       (req_tdata[0]),
      .ap_running      (req_tdata[1]),
      .button_enabled  (button_enabled),
      .active_high     (active_high),
      .ap_hold_ms      (ap_hold_ms),
      .factory_hold_ms (factory_hold_ms),
      .ap_open_ms      (ap_open_ms),
      .result          (core_result)
   );

   tlpd_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .push      (req_accept),
      .push_data (core_result),
      .space     (buf_space),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (rsp_result)
   );

   assign rsp_tdata = {{(tlpd_pkg::RSP_DATA_BITS - $bits(tlpd_pkg::result_type)){1'b0}},
                       rsp_result};

`ifndef SYNTHESIS
   a_accept_gives_result: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> rsp_tvalid)
      else $error("Accepted transaction did not reach the result register.");

   a_start_stop_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tdata[2] && rsp_tdata[3]))
      else $error("Start and stop requested in the same result.");

   a_start_needs_ap_event: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[2] |-> rsp_tdata[1:0] == tlpd_pkg::EVT_AP)
      else $error("Start request without an access point event.");
`endif

endmodule
